// ===== design/hlfd_pkg.sv =====
// Package of the hex line frame decoder: field widths, phase, mode and
// event codes, the character classifier and the structs between modules.
// No dependencies.
package hlfd_pkg;

    localparam int MODE_W  = 2;
    localparam int CHAN_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int EVENT_W = 3;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 2;
    localparam int NIB_W   = 4;
    localparam int ENTRY_W = PHASE_W + NIB_W;
    localparam int DIG_W   = 5;

    localparam int CHANNELS_DEFAULT = 8;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_STD  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REM  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP = 2'd3;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABORT = 2'd2;

    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_START        = 3'd1;
    localparam logic [EVENT_W-1:0] EV_BYTE         = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FRAME_OK     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FRAME_FAIL   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_START_REFUSE = 3'd5;
    localparam logic [EVENT_W-1:0] EV_BYTE_REFUSE  = 3'd6;

    localparam logic [DIG_W-1:0] DIG_DELIM = 5'h10;
    localparam logic [DIG_W-1:0] DIG_BAD   = 5'h11;

    // One channel's stored state as it sits in the state memory.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [NIB_W-1:0]   nibble;
    } hlfd_entry_t;

    // What the step logic hands back to the pipeline.
    typedef struct packed {
        hlfd_entry_t        entry;
        logic [EVENT_W-1:0] event_code;
        logic [BYTE_W-1:0]  data;
    } hlfd_step_t;

    // Hex digits give their value, CR and LF give DIG_DELIM, all else DIG_BAD.
    function automatic logic [DIG_W-1:0] classify(input logic [CHAR_W-1:0] c);
        logic [DIG_W-1:0] d;
        if (c inside {[8'h30:8'h39]})
        begin
            d = DIG_W'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = DIG_W'(c - 8'h61 + 8'd10);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = DIG_W'(c - 8'h41 + 8'd10);
        end
        else if (c inside {8'h0A, 8'h0D})
        begin
            d = DIG_DELIM;
        end
        else
        begin
            d = DIG_BAD;
        end
        return d;
    endfunction

endpackage

// ===== design/hlfd_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module hlfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/hlfd_step.sv =====
// Per-item transition logic of the hex line frame decoder: new phase,
// held nibble, event and assembled byte from one item and its channel state.
// Depends on hlfd_pkg.
module hlfd_step (
    input  logic [hlfd_pkg::MODE_W-1:0] mode,
    input  logic [hlfd_pkg::CHAR_W-1:0] char_in,
    input  logic                        upper_ok,
    input  hlfd_pkg::hlfd_entry_t       cur,
    output hlfd_pkg::hlfd_step_t        res
);

    logic [hlfd_pkg::DIG_W-1:0] dig;
    logic                       is_hex;

    assign dig    = hlfd_pkg::classify(char_in);
    assign is_hex = (dig != hlfd_pkg::DIG_DELIM) && (dig != hlfd_pkg::DIG_BAD);

    always_comb
    begin
        res.entry      = cur;
        res.event_code = hlfd_pkg::EV_NONE;
        res.data       = '0;
        case (mode)
            hlfd_pkg::MODE_START:
            begin
                if (upper_ok)
                begin
                    res.entry.phase = hlfd_pkg::PH_STD;
                    res.event_code  = hlfd_pkg::EV_START;
                end
                else
                begin
                    res.entry.phase = hlfd_pkg::PH_SKIP;
                    res.event_code  = hlfd_pkg::EV_START_REFUSE;
                end
            end
            hlfd_pkg::MODE_CHAR:
            begin
                case (cur.phase)
                    hlfd_pkg::PH_IDLE:
                    begin
                        // An idle channel's hex digit with upper_ok opens a frame.
                        if (dig == hlfd_pkg::DIG_BAD)
                        begin
                            res.entry.phase = hlfd_pkg::PH_SKIP;
                        end
                        else if (is_hex && upper_ok)
                        begin
                            res.entry.nibble = dig[hlfd_pkg::NIB_W-1:0];
                            res.entry.phase  = hlfd_pkg::PH_REM;
                            res.event_code   = hlfd_pkg::EV_START;
                        end
                        else if (is_hex)
                        begin
                            res.entry.phase = hlfd_pkg::PH_SKIP;
                            res.event_code  = hlfd_pkg::EV_START_REFUSE;
                        end
                    end
                    hlfd_pkg::PH_STD:
                    begin
                        if (dig == hlfd_pkg::DIG_BAD)
                        begin
                            res.entry.phase = hlfd_pkg::PH_SKIP;
                            res.event_code  = hlfd_pkg::EV_FRAME_FAIL;
                        end
                        else if (dig == hlfd_pkg::DIG_DELIM)
                        begin
                            res.entry.phase = hlfd_pkg::PH_IDLE;
                            res.event_code  = hlfd_pkg::EV_FRAME_OK;
                        end
                        else
                        begin
                            res.entry.nibble = dig[hlfd_pkg::NIB_W-1:0];
                            res.entry.phase  = hlfd_pkg::PH_REM;
                        end
                    end
                    hlfd_pkg::PH_REM:
                    begin
                        if (dig == hlfd_pkg::DIG_BAD)
                        begin
                            res.entry.phase = hlfd_pkg::PH_SKIP;
                            res.event_code  = hlfd_pkg::EV_FRAME_FAIL;
                        end
                        else if (dig == hlfd_pkg::DIG_DELIM)
                        begin
                            res.entry.phase = hlfd_pkg::PH_IDLE;
                            res.event_code  = hlfd_pkg::EV_FRAME_FAIL;
                        end
                        else
                        begin
                            res.data = {cur.nibble, dig[hlfd_pkg::NIB_W-1:0]};
                            if (upper_ok)
                            begin
                                res.entry.phase = hlfd_pkg::PH_STD;
                                res.event_code  = hlfd_pkg::EV_BYTE;
                            end
                            else
                            begin
                                res.entry.phase = hlfd_pkg::PH_SKIP;
                                res.event_code  = hlfd_pkg::EV_BYTE_REFUSE;
                            end
                        end
                    end
                    default:
                    begin
                        if (dig == hlfd_pkg::DIG_DELIM)
                        begin
                            res.entry.phase = hlfd_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
            hlfd_pkg::MODE_ABORT:
            begin
                if (cur.phase inside {hlfd_pkg::PH_STD, hlfd_pkg::PH_REM})
                begin
                    res.event_code = hlfd_pkg::EV_FRAME_FAIL;
                end
            end
            default:
            begin
                res.entry = cur;
            end
        endcase
    end

endmodule

// ===== design/hex_line_frame_decoder.sv =====
// Top level of the hex line frame decoder: request pipeline around the
// per-channel state memory. Depends on hlfd_pkg, hlfd_ram and hlfd_step.
//
// Usage:
// Input requests (mode, channel, char_in, upper_ok) arrive on the in_valid /
// in_ready channel; each one yields exactly one result (event_res, data_byte,
// out_channel) on the out_valid / out_ready channel, in request order.
// When a request is accepted, the channel's entry is read from the state
// memory into a registered read; in the compute stage the transition is
// computed, the entry is written back and the output register is loaded.
// One request is taken per cycle while the output does not stall, set by
// the single read and single write port of the state memory; a result of
// the previous request on the same channel is forwarded around the memory.
// Reset clears the per-entry valid flags at once, so every channel reads as
// idle with a zero nibble; there is no clearing pass and in_ready is high
// right after reset. When the receiver stalls, the output register holds its
// result, one more request can be taken into the compute stage, and then
// in_ready drops until out_ready returns.
// Requests for a channel at or above CHANNELS give event none and change
// no state.
module hex_line_frame_decoder #(
    parameter int CHANNELS = hlfd_pkg::CHANNELS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hlfd_pkg::MODE_W-1:0]    mode,
    input  logic [hlfd_pkg::CHAN_W-1:0]    channel,
    input  logic [hlfd_pkg::CHAR_W-1:0]    char_in,
    input  logic                           upper_ok,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hlfd_pkg::EVENT_W-1:0]   event_res,
    output logic [hlfd_pkg::BYTE_W-1:0]    data_byte,
    output logic [hlfd_pkg::CHAN_W-1:0]    out_channel
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [AW+hlfd_pkg::CHAN_W-1:0] chan_wide;
    logic [AW-1:0]                  in_addr;
    logic                           in_range;
    logic                           accept;

    logic [CHANNELS-1:0]            valid_reg;
    logic [CHANNELS-1:0]            valid_next;

    logic                           s1_valid_reg;
    logic [hlfd_pkg::MODE_W-1:0]    s1_mode_reg;
    logic [hlfd_pkg::CHAN_W-1:0]    s1_chan_reg;
    logic [hlfd_pkg::CHAR_W-1:0]    s1_char_reg;
    logic                           s1_ok_reg;
    logic                           s1_range_reg;
    logic [AW-1:0]                  s1_addr_reg;
    logic                           s1_vld_reg;
    logic                           s1_fwd_reg;
    hlfd_pkg::hlfd_entry_t          s1_fwd_data_reg;

    logic                           out_valid_reg;
    logic [hlfd_pkg::EVENT_W-1:0]   event_reg;
    logic [hlfd_pkg::BYTE_W-1:0]    byte_reg;
    logic [hlfd_pkg::CHAN_W-1:0]    chan_out_reg;

    logic                           s1_adv;
    logic                           s1_wr;
    logic                           fwd_next;
    logic [hlfd_pkg::ENTRY_W-1:0]   ram_rdata;
    hlfd_pkg::hlfd_entry_t          cur;
    hlfd_pkg::hlfd_step_t           step_res;

    assign chan_wide = {{AW{1'b0}}, channel};
    assign in_addr   = chan_wide[AW-1:0];
    assign in_range  = (32'(channel) < CHANNELS);

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;
    assign s1_wr    = s1_valid_reg && s1_adv && s1_range_reg;

    // The entry being written this cycle would be read stale by the memory.
    assign fwd_next = s1_wr && in_range && (in_addr == s1_addr_reg);

    hlfd_ram #(
        .WIDTH (hlfd_pkg::ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_addr_reg),
        .wdata (step_res.entry),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            cur = s1_fwd_data_reg;
        end
        else if (s1_vld_reg)
        begin
            cur = ram_rdata;
        end
        else
        begin
            cur.phase  = hlfd_pkg::PH_IDLE;
            cur.nibble = '0;
        end
    end

    hlfd_step u_step (
        .mode     (s1_mode_reg),
        .char_in  (s1_char_reg),
        .upper_ok (s1_ok_reg),
        .cur      (cur),
        .res      (step_res)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (s1_wr)
        begin
            valid_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                s1_fwd_reg <= fwd_next;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg     <= mode;
            s1_chan_reg     <= channel;
            s1_char_reg     <= char_in;
            s1_ok_reg       <= upper_ok;
            s1_range_reg    <= in_range;
            s1_addr_reg     <= in_addr;
            s1_vld_reg      <= in_range && valid_reg[in_addr];
            s1_fwd_data_reg <= step_res.entry;
        end
        if (s1_adv && s1_valid_reg)
        begin
            event_reg    <= s1_range_reg ? step_res.event_code : hlfd_pkg::EV_NONE;
            byte_reg     <= s1_range_reg ? step_res.data : '0;
            chan_out_reg <= s1_chan_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign data_byte   = byte_reg;
    assign out_channel = chan_out_reg;

endmodule

// ===== design/hlfd_checker.sv =====
// Port-level checker for the hex line frame decoder and its bind to the top.
// Depends on hlfd_pkg and hex_line_frame_decoder.
module hlfd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [hlfd_pkg::EVENT_W-1:0] event_res,
    input logic [hlfd_pkg::BYTE_W-1:0]  data_byte,
    input logic [hlfd_pkg::CHAN_W-1:0]  out_channel
);

    // A stalled result must hold still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(data_byte) && $stable(out_channel))
        else $error("stalled result changed");

    // Only the defined event codes are ever produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= hlfd_pkg::EV_BYTE_REFUSE)
        else $error("undefined event code");

    // The byte field is zero unless the event carries a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != hlfd_pkg::EV_BYTE && event_res != hlfd_pkg::EV_BYTE_REFUSE
            |-> data_byte == '0)
        else $error("byte set on an event without data");

    // No result can appear without a request accepted before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a request");

endmodule

bind hex_line_frame_decoder hlfd_checker u_hlfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .data_byte   (data_byte),
    .out_channel (out_channel)
);

// ===== bench/hex_line_frame_decoder_test.sv =====
`timescale 1ns / 1ps
// Testbench of hex_line_frame_decoder: drives requests, predicts each event per channel
// and checks every result. Depends on hlfd_pkg and the decoder RTL.
module hex_line_frame_decoder_test;

    localparam int NUM_CHANNELS = 8;
    localparam int RANDOM_REQUESTS = 1225;
    localparam int QUIET_TAIL = 150;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam logic [hlfd_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [hlfd_pkg::CHAR_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [hlfd_pkg::CHAR_W-1:0] CHAR_CR = 8'h0D;

    // Keeps a shadow copy of every channel's phase and nibble and the queue
    // of events still owed by the decoder.
    class frame_event_scoreboard;
        typedef struct packed {
            logic [hlfd_pkg::EVENT_W-1:0] event_code;
            logic [hlfd_pkg::BYTE_W-1:0]  assembled;
            logic [hlfd_pkg::CHAN_W-1:0]  chan;
        } frame_result_t;

        logic [hlfd_pkg::PHASE_W-1:0] chan_phase [NUM_CHANNELS];
        logic [hlfd_pkg::NIB_W-1:0]   chan_nibble [NUM_CHANNELS];
        frame_result_t                expected_q [$];
        int                           errors;

        function new();
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_phase[i] = hlfd_pkg::PH_IDLE;
                chan_nibble[i] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // The low nibble of a letter digit plus nine gives its value.
        function bit decode_hex(input logic [hlfd_pkg::CHAR_W-1:0] c,
                                output logic [hlfd_pkg::NIB_W-1:0] v);
            v = '0;
            if (c inside {["0":"9"]})
            begin
                v = c[3:0];
                return 1'b1;
            end
            if (c inside {["a":"f"], ["A":"F"]})
            begin
                v = c[3:0] + 4'd9;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(input logic [hlfd_pkg::MODE_W-1:0] m,
                                   input logic [hlfd_pkg::CHAN_W-1:0] ch,
                                   input logic [hlfd_pkg::CHAR_W-1:0] c, input logic ok);
            logic [hlfd_pkg::PHASE_W-1:0] ph;
            logic [hlfd_pkg::NIB_W-1:0]   v;
            frame_result_t                res;
            bit                           is_hex;
            bit                           is_delim;
            res.event_code = hlfd_pkg::EV_NONE;
            res.assembled = '0;
            res.chan = ch;
            is_hex = decode_hex(c, v);
            is_delim = (c == CHAR_LF) || (c == CHAR_CR);
            if (int'(ch) < NUM_CHANNELS)
            begin
                ph = chan_phase[ch];
                case (m)
                    hlfd_pkg::MODE_START:
                    begin
                        ph = ok ? hlfd_pkg::PH_STD : hlfd_pkg::PH_SKIP;
                        res.event_code = ok ? hlfd_pkg::EV_START : hlfd_pkg::EV_START_REFUSE;
                    end
                    hlfd_pkg::MODE_CHAR:
                    begin
                        case (ph)
                            hlfd_pkg::PH_IDLE:
                            begin
                                if (is_delim)
                                begin
                                    ph = hlfd_pkg::PH_IDLE;
                                end
                                else if (!is_hex)
                                begin
                                    ph = hlfd_pkg::PH_SKIP;
                                end
                                else if (ok)
                                begin
                                    chan_nibble[ch] = v;
                                    ph = hlfd_pkg::PH_REM;
                                    res.event_code = hlfd_pkg::EV_START;
                                end
                                else
                                begin
                                    ph = hlfd_pkg::PH_SKIP;
                                    res.event_code = hlfd_pkg::EV_START_REFUSE;
                                end
                            end
                            hlfd_pkg::PH_STD:
                            begin
                                if (is_delim)
                                begin
                                    ph = hlfd_pkg::PH_IDLE;
                                    res.event_code = hlfd_pkg::EV_FRAME_OK;
                                end
                                else if (!is_hex)
                                begin
                                    ph = hlfd_pkg::PH_SKIP;
                                    res.event_code = hlfd_pkg::EV_FRAME_FAIL;
                                end
                                else
                                begin
                                    chan_nibble[ch] = v;
                                    ph = hlfd_pkg::PH_REM;
                                end
                            end
                            hlfd_pkg::PH_REM:
                            begin
                                if (is_delim)
                                begin
                                    ph = hlfd_pkg::PH_IDLE;
                                    res.event_code = hlfd_pkg::EV_FRAME_FAIL;
                                end
                                else if (!is_hex)
                                begin
                                    ph = hlfd_pkg::PH_SKIP;
                                    res.event_code = hlfd_pkg::EV_FRAME_FAIL;
                                end
                                else
                                begin
                                    res.assembled = {chan_nibble[ch], v};
                                    ph = ok ? hlfd_pkg::PH_STD : hlfd_pkg::PH_SKIP;
                                    res.event_code = ok ? hlfd_pkg::EV_BYTE
                                                        : hlfd_pkg::EV_BYTE_REFUSE;
                                end
                            end
                            default:
                            begin
                                if (is_delim)
                                begin
                                    ph = hlfd_pkg::PH_IDLE;
                                end
                            end
                        endcase
                    end
                    hlfd_pkg::MODE_ABORT:
                    begin
                        if (ph inside {hlfd_pkg::PH_STD, hlfd_pkg::PH_REM})
                        begin
                            res.event_code = hlfd_pkg::EV_FRAME_FAIL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                chan_phase[ch] = ph;
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(input logic [hlfd_pkg::EVENT_W-1:0] ev,
                          input logic [hlfd_pkg::BYTE_W-1:0] assembled,
                          input logic [hlfd_pkg::CHAN_W-1:0] chan);
            frame_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result ev=%0d ch=%0d with no request pending",
                                          ev, chan));
            end
            else
            begin
                want = expected_q.pop_front();
                if (ev !== want.event_code)
                begin
                    report_mismatch($sformatf("event_res %0d, expected %0d (ch %0d)",
                                              ev, want.event_code, want.chan));
                end
                if (assembled !== want.assembled)
                begin
                    report_mismatch($sformatf("data_byte %h, expected %h (ch %0d)",
                                              assembled, want.assembled, want.chan));
                end
                if (chan !== want.chan)
                begin
                    report_mismatch($sformatf("out_channel %0d, expected %0d",
                                              chan, want.chan));
                end
            end
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [hlfd_pkg::MODE_W-1:0]   mode;
    logic [hlfd_pkg::CHAN_W-1:0]   channel;
    logic [hlfd_pkg::CHAR_W-1:0]   char_in;
    logic                          upper_ok;
    logic                          out_valid;
    logic                          out_ready;
    logic [hlfd_pkg::EVENT_W-1:0]  event_res;
    logic [hlfd_pkg::BYTE_W-1:0]   data_byte;
    logic [hlfd_pkg::CHAN_W-1:0]   out_channel;

    frame_event_scoreboard         sb;
    bit                            idle_on;
    bit                            long_hold_req;
    logic [hlfd_pkg::CHAN_W-1:0]   last_channel;

    hex_line_frame_decoder #(
        .CHANNELS(NUM_CHANNELS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .channel(channel),
        .char_in(char_in),
        .upper_ok(upper_ok),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_res(event_res),
        .data_byte(data_byte),
        .out_channel(out_channel)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Both handshakes are sampled with the values they had before the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_request(mode, channel, char_in, upper_ok);
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(event_res, data_byte, out_channel);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 9);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [hlfd_pkg::CHAR_W-1:0] hex_char(
        input logic [hlfd_pkg::NIB_W-1:0] v, input bit caps);
        if (v < 4'd10)
        begin
            return 8'h30 + v;
        end
        return (caps ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input logic [hlfd_pkg::MODE_W-1:0] m,
                                input logic [hlfd_pkg::CHAN_W-1:0] ch,
                                input logic [hlfd_pkg::CHAR_W-1:0] c, input logic ok);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        channel <= ch;
        char_in <= c;
        upper_ok <= ok;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_directed();
        send_request(hlfd_pkg::MODE_CHAR, 3'd0, "A", 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd0, "f", 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd0, "0", 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd0, "9", 1'b0);
        send_request(hlfd_pkg::MODE_CHAR, 3'd0, 8'hFF, 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd0, CHAR_LF, 1'b1);
        send_request(hlfd_pkg::MODE_START, 3'd7, 8'h00, 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd7, CHAR_CR, 1'b1);
        send_request(hlfd_pkg::MODE_START, 3'd7, 8'hFF, 1'b0);
        send_request(hlfd_pkg::MODE_START, 3'd7, 8'h00, 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd7, ":", 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd3, 8'h00, 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd3, CHAR_CR, 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd3, "a", 1'b0);
        send_request(hlfd_pkg::MODE_CHAR, 3'd3, CHAR_LF, 1'b0);
        send_request(hlfd_pkg::MODE_START, 3'd5, 8'h00, 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd5, "F", 1'b1);
        send_request(hlfd_pkg::MODE_ABORT, 3'd5, 8'h00, 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd5, "F", 1'b1);
        send_request(hlfd_pkg::MODE_ABORT, 3'd5, 8'h00, 1'b0);
        send_request(hlfd_pkg::MODE_CHAR, 3'd5, "7", 1'b1);
        send_request(hlfd_pkg::MODE_CHAR, 3'd5, CHAR_LF, 1'b1);
        send_request(hlfd_pkg::MODE_ABORT, 3'd5, 8'h00, 1'b1);
        send_request(MODE_UNUSED, 3'd6, 8'hFF, 1'b1);
    endtask

    // Mostly hex digits and delimiters on a channel that often repeats, so
    // frames build up and back-to-back requests hit the same entry.
    task automatic send_random_request(output bit counted);
        logic [hlfd_pkg::MODE_W-1:0] m;
        logic [hlfd_pkg::CHAN_W-1:0] ch;
        logic [hlfd_pkg::CHAR_W-1:0] c;
        logic                        ok;
        int                          pick;
        ch = ($urandom_range(0, 1) == 0) ? last_channel
                                         : hlfd_pkg::CHAN_W'($urandom_range(0, 7));
        c = hlfd_pkg::CHAR_W'($urandom_range(0, 255));
        ok = ($urandom_range(0, 9) != 0);
        m = hlfd_pkg::MODE_CHAR;
        pick = $urandom_range(0, 99);
        if (pick < 68)
        begin
            c = hex_char(hlfd_pkg::NIB_W'($urandom_range(0, 15)), $urandom_range(0, 1) == 1);
        end
        else if (pick < 80)
        begin
            c = ($urandom_range(0, 1) == 0) ? CHAR_LF : CHAR_CR;
        end
        else if (pick < 88)
        begin
            m = hlfd_pkg::MODE_START;
        end
        else if (pick < 94)
        begin
            m = hlfd_pkg::MODE_CHAR;
        end
        else if (pick < 98)
        begin
            m = hlfd_pkg::MODE_ABORT;
        end
        else
        begin
            m = MODE_UNUSED;
        end
        last_channel = ch;
        send_request(m, ch, c, ok);
        counted = (m != MODE_UNUSED);
    endtask

    initial
    begin
        int  sent;
        bit  counted;
        sb = new();
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        last_channel = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = hlfd_pkg::MODE_START;
        channel = '0;
        char_in = '0;
        upper_ok = 1'b0;
        counted = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            if (sent == 300 && counted)
            begin
                // Hold the receiver off while requests keep coming.
                long_hold_req = 1'b1;
            end
            if (sent == 700)
            begin
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                begin
                    @(posedge clk);
                end
            end
            if (sent == RANDOM_REQUESTS - QUIET_TAIL)
            begin
                idle_on = 1'b0;
            end
            send_random_request(counted);
            if (counted)
            begin
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
